// ----- sv/csds_pkg.sv -----
// Package for the color second-difference stencil.
// Holds frame limits, register index codes and the pixel and result word types.
// No dependencies; the top level imports it.
package csds_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;
	localparam int MIN_DIM    = 3;

	// Width of a frame size register and of the position counters.
	localparam int DIM_W  = 11;
	localparam int CNT_W  = 10;
	localparam int ADDR_W = $clog2(MAX_WIDTH);

	localparam int CHAN_W = 8;
	localparam int RES_W  = 20;
	localparam int POS_W  = 10;

	// Configuration port.
	localparam int REG_IDX_W = 1;
	localparam int CFG_W     = DIM_W;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_FRAME_HEIGHT = 1'd0,
		REG_FRAME_WIDTH  = 1'd1
	} reg_idx_t;

	typedef struct packed {
		logic [CHAN_W-1:0] red_in;
		logic [CHAN_W-1:0] green_in;
		logic [CHAN_W-1:0] blue_in;
	} pix_word_t;

	typedef struct packed {
		logic [POS_W-1:0]        pixel_row;
		logic [POS_W-1:0]        pixel_col;
		logic signed [RES_W-1:0] vert_red;
		logic signed [RES_W-1:0] vert_green;
		logic signed [RES_W-1:0] vert_blue;
		logic signed [RES_W-1:0] horiz_red;
		logic signed [RES_W-1:0] horiz_green;
		logic signed [RES_W-1:0] horiz_blue;
		logic                    last_of_run;
	} res_word_t;

	localparam int PIX_W = $bits(pix_word_t);

endpackage

// ----- sv/csds_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for the two line stores of the stencil; no dependencies.
module csds_ram #(
	parameter int DATA_W = 24,
	parameter int DEPTH  = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [DATA_W-1:0]        wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [DATA_W-1:0]        rd_data
);

	logic [DATA_W-1:0] mem [DEPTH];

	// A read and a write at the same edge return the old contents.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ----- sv/color_second_difference_stencil.sv -----
// Color second-difference stencil: top level.
// Depends on csds_pkg and on csds_ram for the two line stores.
//
// This block takes RGB pixels in raster order and returns, for every pixel, the vertical
// second difference (up - 2*center + down) times the frame height and the horizontal
// second difference (left - 2*center + right) times the frame width, per channel, with
// zero on the border rows and columns. A pixel on row r produces the result for row r-1
// at the same column, so results run one row behind the input; pixels on row 0 produce
// nothing. Pixels on the last row also produce the last-row results one column behind,
// and the last pixel of the frame produces a third result that closes the frame. The
// last result caused by a pixel carries last_of_run. Throughput is one pixel per cycle
// on every row but the last while the output does not stall; on the last row the pixel
// in column 0 gives one result word, every later pixel gives two (three on the final
// pixel), and the single result register takes them one at a time while the input
// stalls. A result passes through the input stage and then the result register.
// Writing either frame size register restarts the frame at row 0, column 0; sizes are
// clamped to the range 3 to 1024. The line stores need no clearing after reset: the
// first two rows of every frame fill them before any data read from them is used.
module color_second_difference_stencil
	import csds_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// Pixel channel.
	input  logic                 pix_valid,
	output logic                 pix_stall,
	input  pix_word_t            pix_word,
	// Result channel.
	output logic                 res_valid,
	input  logic                 res_stall,
	output res_word_t            res_word,
	// Configuration write port.
	input  logic                 cfg_we,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	// Second difference a - 2*b + c of one channel, in the range -510 to 510.
	function automatic logic signed [DIM_W-1:0] diff2(
		input logic [CHAN_W-1:0] a,
		input logic [CHAN_W-1:0] b,
		input logic [CHAN_W-1:0] c
	);
		logic [DIM_W-1:0] sum;
		sum = {{(DIM_W-CHAN_W){1'b0}}, a} + {{(DIM_W-CHAN_W){1'b0}}, c}
			- {{(DIM_W-CHAN_W-1){1'b0}}, b, 1'b0};
		return signed'(sum);
	endfunction

	// Scaled result; with the sizes clamped the product always fits the result width.
	function automatic logic signed [RES_W-1:0] scale(
		input logic signed [DIM_W-1:0] d,
		input logic [DIM_W-1:0]        s
	);
		logic signed [DIM_W+DIM_W:0] prod;
		prod = d * signed'({1'b0, s});
		return prod[RES_W-1:0];
	endfunction

	// ------------------------------------------------------------------
	// Configuration and clamped frame size
	// ------------------------------------------------------------------
	logic [DIM_W-1:0] frame_height_q, frame_width_q;
	logic [DIM_W-1:0] height, width;

	always_comb begin
		if (frame_height_q < DIM_W'(MIN_DIM)) begin
			height = DIM_W'(MIN_DIM);
		end else if (frame_height_q > DIM_W'(MAX_HEIGHT)) begin
			height = DIM_W'(MAX_HEIGHT);
		end else begin
			height = frame_height_q;
		end
		if (frame_width_q < DIM_W'(MIN_DIM)) begin
			width = DIM_W'(MIN_DIM);
		end else if (frame_width_q > DIM_W'(MAX_WIDTH)) begin
			width = DIM_W'(MAX_WIDTH);
		end else begin
			width = frame_width_q;
		end
	end

	// ------------------------------------------------------------------
	// Handshakes
	// ------------------------------------------------------------------
	// pend_s1 holds the results still owed by the pixel in the input stage:
	// bit 0 is the result for the row above, bit 1 the last-row result one
	// column behind, bit 2 the closing result of the frame.
	logic [2:0] pend_s1;
	logic [2:0] pend_clr;
	logic       res_valid_q;
	logic       res_free;
	logic       emit;
	logic       pix_accept;

	assign res_free   = !res_valid_q || !res_stall;
	assign emit       = res_free && (pend_s1 != 3'b000);
	assign pend_clr   = pend_s1 & (pend_s1 - 3'd1);
	// The pixel stage frees up once its last owed result moves to the output.
	assign pix_stall  = (pend_s1 != 3'b000) && !(res_free && (pend_clr == 3'b000));
	assign pix_accept = pix_valid && !pix_stall;

	// ------------------------------------------------------------------
	// Position counters and line store addressing
	// ------------------------------------------------------------------
	logic [CNT_W-1:0] row_q, col_q;
	logic             last_col, last_row;
	logic [DIM_W-1:0] col_plus1, col_plus2;
	logic [ADDR_W-1:0] older_rd_addr, prior_rd_addr;

	assign last_col = ({1'b0, col_q} == width - DIM_W'(1));
	assign last_row = ({1'b0, row_q} == height - DIM_W'(1));

	// The stores are read ahead: the older store one column ahead and the
	// prior store two columns ahead, wrapping into the next row, so the data
	// are waiting in the read registers when the next pixel arrives.
	assign col_plus1 = {1'b0, col_q} + DIM_W'(1);
	assign col_plus2 = {1'b0, col_q} + DIM_W'(2);

	always_comb begin
		if (col_plus1 >= width) begin
			older_rd_addr = '0;
		end else begin
			older_rd_addr = col_plus1[ADDR_W-1:0];
		end
		if (col_plus2 >= width) begin
			prior_rd_addr = ADDR_W'(col_plus2 - width);
		end else begin
			prior_rd_addr = col_plus2[ADDR_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_height_q <= DIM_W'(MAX_HEIGHT);
			frame_width_q  <= DIM_W'(MAX_WIDTH);
			row_q          <= '0;
			col_q          <= '0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_data;
				default: ;
			endcase
			row_q <= '0;
			col_q <= '0;
		end else if (pix_accept) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + CNT_W'(1);
			end else begin
				col_q <= col_q + CNT_W'(1);
			end
		end
	end

	// ------------------------------------------------------------------
	// Line stores and the sliding window
	// ------------------------------------------------------------------
	// older holds the row two above the input, prior the row just above.
	logic [PIX_W-1:0] older_rd, prior_rd;
	pix_word_t        center_q;   // prior store at the current column
	pix_word_t        left_q;     // prior store one column to the left
	pix_word_t        cur1_q;     // input one column back
	pix_word_t        cur2_q;     // input two columns back

	csds_ram #(
		.DATA_W (PIX_W),
		.DEPTH  (MAX_WIDTH)
	) u_older_ram (
		.clk     (clk),
		.wr_en   (pix_accept),
		.wr_addr (col_q),
		.wr_data (center_q),
		.rd_en   (pix_accept),
		.rd_addr (older_rd_addr),
		.rd_data (older_rd)
	);

	csds_ram #(
		.DATA_W (PIX_W),
		.DEPTH  (MAX_WIDTH)
	) u_prior_ram (
		.clk     (clk),
		.wr_en   (pix_accept),
		.wr_addr (col_q),
		.wr_data (pix_word),
		.rd_en   (pix_accept),
		.rd_addr (prior_rd_addr),
		.rd_data (prior_rd)
	);

	always_ff @(posedge clk) begin
		if (pix_accept) begin
			left_q   <= center_q;
			center_q <= pix_word_t'(prior_rd);
			cur1_q   <= pix_word;
			cur2_q   <= cur1_q;
		end
	end

	// ------------------------------------------------------------------
	// Input stage: the accepted pixel and its stencil
	// ------------------------------------------------------------------
	pix_word_t        cur_s1, up_s1, center_s1, right_s1, left_s1, cur1_s1, cur2_s1;
	logic [CNT_W-1:0] row_s1, col_s1;
	logic             v_en_s1, h0_en_s1, h1_en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1 <= '0;
		end else if (pix_accept) begin
			pend_s1 <= {last_row && last_col,
				last_row && (col_q != '0),
				row_q != '0};
		end else if (emit) begin
			pend_s1 <= pend_clr;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_accept) begin
			cur_s1    <= pix_word;
			up_s1     <= pix_word_t'(older_rd);
			center_s1 <= center_q;
			right_s1  <= pix_word_t'(prior_rd);
			left_s1   <= left_q;
			cur1_s1   <= cur1_q;
			cur2_s1   <= cur2_q;
			row_s1    <= row_q;
			col_s1    <= col_q;
			v_en_s1   <= row_q >= CNT_W'(2);
			h0_en_s1  <= (col_q != '0) && !last_col;
			h1_en_s1  <= col_q >= CNT_W'(2);
		end
	end

	// ------------------------------------------------------------------
	// Result selection and arithmetic
	// ------------------------------------------------------------------
	logic      sel_above, sel_behind;
	logic      v_on, h_on;
	pix_word_t ha, hb, hc;
	res_word_t res_next;

	// The lowest owed result goes out first.
	assign sel_above  = pend_s1[0];
	assign sel_behind = !pend_s1[0] && pend_s1[1];
	assign v_on       = sel_above && v_en_s1;
	assign h_on       = (sel_above && h0_en_s1) || (sel_behind && h1_en_s1);

	always_comb begin
		if (sel_above) begin
			ha = left_s1;
			hb = center_s1;
			hc = right_s1;
		end else begin
			ha = cur2_s1;
			hb = cur1_s1;
			hc = cur_s1;
		end

		res_next.pixel_row = sel_above ? row_s1 - CNT_W'(1) : row_s1;
		res_next.pixel_col = sel_behind ? col_s1 - CNT_W'(1) : col_s1;

		res_next.vert_red    = v_on ? scale(diff2(up_s1.red_in, center_s1.red_in,
			cur_s1.red_in), height) : '0;
		res_next.vert_green  = v_on ? scale(diff2(up_s1.green_in, center_s1.green_in,
			cur_s1.green_in), height) : '0;
		res_next.vert_blue   = v_on ? scale(diff2(up_s1.blue_in, center_s1.blue_in,
			cur_s1.blue_in), height) : '0;
		res_next.horiz_red   = h_on ? scale(diff2(ha.red_in, hb.red_in, hc.red_in), width)
			: '0;
		res_next.horiz_green = h_on ? scale(diff2(ha.green_in, hb.green_in, hc.green_in),
			width) : '0;
		res_next.horiz_blue  = h_on ? scale(diff2(ha.blue_in, hb.blue_in, hc.blue_in),
			width) : '0;
		res_next.last_of_run = (pend_clr == 3'b000);
	end

	// ------------------------------------------------------------------
	// Result register
	// ------------------------------------------------------------------
	res_word_t res_word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_free) begin
			res_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_word_q <= res_next;
		end
	end

	assign res_valid = res_valid_q;
	assign res_word  = res_word_q;

endmodule
